// ===== rtl/sigact_pkg.sv =====
package sigact_pkg;

  // table size and fixed point format
  localparam int TABLE_ENTRIES = 256;
  localparam int FRAC_BITS     = 12;

  // io widths fixed by the field formats
  localparam int DataW = 16;

  // widths derived from the format
  localparam int TW   = FRAC_BITS + 1;                      // table entry, 0 to one
  localparam int RW   = FRAC_BITS + 4;                      // remainder out of D
  localparam int IW   = $clog2(TABLE_ENTRIES + 1);          // table index
  localparam int PW   = RW + IW;                            // position u * entries
  localparam int XW   = (FRAC_BITS + 6 > 18) ? FRAC_BITS + 6 : 18;
  localparam int SW   = 2 * FRAC_BITS + 6;                  // interpolation sum
  localparam int DW   = 2 * TW;                             // s * (one - s)
  localparam int MW   = DW + DataW;                         // grad * derivative
  localparam int QW   = MW + 1 - 2 * FRAC_BITS;             // rounded gradient

  // range limits and rounding constants
  localparam longint XLoL = -(longint'(8) << FRAC_BITS);
  localparam longint XHiL = longint'(8) << FRAC_BITS;
  localparam logic signed [XW-1:0] XLo = XW'(XLoL);
  localparam logic signed [XW-1:0] XHi = XW'(XHiL);
  localparam logic [RW:0]   DFull  = (RW+1)'(longint'(1) << RW);
  localparam logic [SW-1:0] HalfD  = SW'(longint'(1) << (RW - 1));
  localparam logic [TW-1:0] One    = TW'(longint'(1) << FRAC_BITS);
  localparam logic [MW:0]   HalfSq = (MW+1)'(longint'(1) << (2 * FRAC_BITS - 1));

  // control that travels alongside the datapath
  typedef struct packed {
    logic                    valid;
    logic                    op;
    logic signed [DataW-1:0] grad;
    logic                    below;
    logic                    above;
  } sigact_ctl_t;

  typedef logic [TW-1:0] sig_tab_t [TABLE_ENTRIES+1];

  // restoring division, used only while the table is built at elaboration
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-f) in q30 for 0 <= f <= 1.0, truncated taylor series
  function automatic longint unsigned exp_neg_q30(longint unsigned f);
    longint signed   sum;
    longint unsigned term;
    sum  = longint'(1) << 30;
    term = longint'(1) << 30;
    for (longint unsigned k = 1; k <= 24; k++) begin
      term = udiv64((term * f) >> 30, k);
      if (k[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    return longint'(sum);
  endfunction

  // sigmoid samples over [-8, 8], evaluated at elaboration
  function automatic sig_tab_t build_sig_table();
    sig_tab_t        tab;
    longint unsigned em1;
    longint signed   a;
    longint unsigned t;
    longint unsigned whole;
    longint unsigned rem;
    longint unsigned e;
    longint unsigned den;
    longint unsigned num;
    em1 = exp_neg_q30(longint'(1) << 30);
    for (int i = 0; i <= TABLE_ENTRIES; i++) begin
      a     = 16 * longint'(i) - 8 * longint'(TABLE_ENTRIES);
      t     = (a < 0) ? -a : a;
      whole = t / TABLE_ENTRIES;
      rem   = t % TABLE_ENTRIES;
      e     = exp_neg_q30((rem << 30) / TABLE_ENTRIES);
      for (longint unsigned w = 0; w < whole; w++) begin
        e = (e * em1) >> 30;
      end
      den    = (longint'(1) << 30) + e;
      num    = (a >= 0) ? (longint'(1) << 30) : e;
      tab[i] = TW'(udiv64((num << FRAC_BITS) + den / 2, den));
    end
    return tab;
  endfunction

  localparam sig_tab_t SigTable = build_sig_table();

endpackage

// ===== rtl/sigact_index.sv =====
module sigact_index
  import sigact_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic                    operation_i,
  input  logic signed [DataW-1:0] activation_in_i,
  input  logic signed [DataW-1:0] grad_in_i,
  output sigact_ctl_t             ctl_o,
  output logic [IW-1:0]           idx_o,
  output logic [RW-1:0]           rem_o
);

  sigact_ctl_t             ctl_d, ctl_q;
  logic [IW-1:0]           idx_d, idx_q;
  logic [RW-1:0]           rem_d, rem_q;
  logic signed [XW-1:0]    x_ext;
  logic signed [XW-1:0]    u_full;
  logic [RW-1:0]           u;
  logic [PW-1:0]           pos;

  // range check and table position
  always_comb begin
    x_ext        = XW'(activation_in_i);
    ctl_d.valid  = accept_i;
    ctl_d.op     = operation_i;
    ctl_d.grad   = grad_in_i;
    ctl_d.below  = x_ext < XLo;
    ctl_d.above  = x_ext >= XHi;
    u_full       = x_ext - XLo;
    u            = (ctl_d.below || ctl_d.above) ? '0 : u_full[RW-1:0];
    pos          = PW'(u) * PW'(TABLE_ENTRIES);
    idx_d        = pos[PW-1:RW];
    rem_d        = pos[RW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    rem_q <= rem_d;
  end

  assign ctl_o = ctl_q;
  assign idx_o = idx_q;
  assign rem_o = rem_q;

endmodule

// ===== rtl/sigact_interp.sv =====
module sigact_interp
  import sigact_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sigact_ctl_t   ctl_i,
  input  logic [IW-1:0] idx_i,
  input  logic [RW-1:0] rem_i,
  output sigact_ctl_t   ctl_o,
  output logic [TW-1:0] sig_o
);

  // stage a: table lookup
  sigact_ctl_t   ctl_a_q;
  logic [TW-1:0] t0_q, t1_q;
  logic [RW-1:0] rem_a_q;
  logic [IW-1:0] idx_next;

  assign idx_next = idx_i + IW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
    end else begin
      ctl_a_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    t0_q    <= SigTable[idx_i];
    t1_q    <= SigTable[idx_next];
    rem_a_q <= rem_i;
  end

  // stage b: weight both neighbors
  sigact_ctl_t   ctl_b_q;
  logic [SW-1:0] w0_q, w1_q;
  logic [RW:0]   rem_inv;

  assign rem_inv = DFull - (RW+1)'(rem_a_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_b_q <= '0;
    end else begin
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w0_q <= SW'(t0_q) * SW'(rem_inv);
    w1_q <= SW'(t1_q) * SW'(rem_a_q);
  end

  // stage c: sum, round half up, clamp out of range
  sigact_ctl_t   ctl_c_q;
  logic [TW-1:0] sig_d, sig_q;
  logic [SW-1:0] sum;

  always_comb begin
    sum   = w0_q + w1_q + HalfD;
    sig_d = sum[RW +: TW];
    if (ctl_b_q.below) sig_d = '0;
    if (ctl_b_q.above) sig_d = One;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_c_q <= '0;
    end else begin
      ctl_c_q <= ctl_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sig_q <= sig_d;
  end

  assign ctl_o = ctl_c_q;
  assign sig_o = sig_q;

endmodule

// ===== rtl/sigact_grad.sv =====
module sigact_grad
  import sigact_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sigact_ctl_t             ctl_i,
  input  logic [TW-1:0]           sig_i,
  output logic                    done_o,
  output logic signed [DataW-1:0] value_out_o
);

  // stage d: sigmoid derivative
  sigact_ctl_t   ctl_d_q;
  logic [TW-1:0] sig_d_q;
  logic [DW-1:0] dv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_d_q <= '0;
    end else begin
      ctl_d_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sig_d_q <= sig_i;
    dv_q    <= DW'(sig_i) * DW'(One - sig_i);
  end

  // stage e: scale by gradient magnitude
  sigact_ctl_t      ctl_e_q;
  logic [TW-1:0]    sig_e_q;
  logic [MW-1:0]    mag_q;
  logic [DataW-1:0] g_abs;

  assign g_abs = ctl_d_q.grad[DataW-1] ? DataW'(-ctl_d_q.grad) : DataW'(ctl_d_q.grad);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_e_q <= '0;
    end else begin
      ctl_e_q <= ctl_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sig_e_q <= sig_d_q;
    mag_q   <= MW'(g_abs) * MW'(dv_q);
  end

  // stage f: round, apply sign, saturate, select mode
  logic                    done_d, done_q;
  logic signed [DataW-1:0] value_d, value_q;
  logic [MW:0]             mag_rnd;
  logic [QW-1:0]           quo;

  always_comb begin
    mag_rnd = (MW+1)'(mag_q) + HalfSq;
    quo     = mag_rnd[MW:2*FRAC_BITS];
    done_d  = ctl_e_q.valid;
    if (!ctl_e_q.op) begin
      if (32'(sig_e_q) > 32'd32767) value_d = 16'sh7fff;
      else                          value_d = DataW'(sig_e_q);
    end else if (ctl_e_q.grad[DataW-1]) begin
      if (32'(quo) > 32'd32768) value_d = 16'sh8000;
      else                      value_d = -(DataW'(quo));
    end else begin
      if (32'(quo) > 32'd32767) value_d = 16'sh7fff;
      else                      value_d = DataW'(quo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign done_o      = done_q;
  assign value_out_o = value_q;

endmodule

// ===== rtl/sigmoid_activation_fwd_bwd_top.sv =====
// done_o and value_out_o come from the registers of stage f, the last pipeline stage
// throughput: one transaction per cycle; busy is never raised, every stage
// of the seven stage pipeline advances each cycle and the receiver cannot stall
// the sigmoid table is a constant lookup read at two neighboring entries in stage two
// reset (rst_ni low, asynchronous) clears all valid bits; no clearing pass
module sigmoid_activation_fwd_bwd_top
  import sigact_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    operation_i,
  input  logic signed [DataW-1:0] activation_in_i,
  input  logic signed [DataW-1:0] grad_in_i,
  output logic                    done_o,
  output logic signed [DataW-1:0] value_out_o
);

  sigact_ctl_t   ctl_idx, ctl_sig;
  logic [IW-1:0] idx;
  logic [RW-1:0] rem;
  logic [TW-1:0] sig;
  logic          accept;

  // pipeline always moves, never busy
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // table position
  sigact_index u_index (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .operation_i    (operation_i),
    .activation_in_i(activation_in_i),
    .grad_in_i      (grad_in_i),
    .ctl_o          (ctl_idx),
    .idx_o          (idx),
    .rem_o          (rem)
  );

  // sigmoid by interpolation
  sigact_interp u_interp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl_idx),
    .idx_i (idx),
    .rem_i (rem),
    .ctl_o (ctl_sig),
    .sig_o (sig)
  );

  // derivative, gradient and output
  sigact_grad u_grad (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl_sig),
    .sig_i      (sig),
    .done_o     (done_o),
    .value_out_o(value_out_o)
  );

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import sigact_pkg::*;

  localparam logic OP_FWD = 1'b0;
  localparam logic OP_BWD = 1'b1;

  localparam int RAND_ELEMS   = 1300;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int CALM_TAIL    = 150;
  localparam longint QONE     = longint'(1) << 30;

  typedef struct packed {
    logic                    op;
    logic signed [DataW-1:0] act;
    logic signed [DataW-1:0] grad;
  } elem_t;

  typedef struct packed {
    elem_t                   elem;
    logic signed [DataW-1:0] value;
  } due_t;

  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    start           = 1'b0;
  logic                    busy;
  logic                    operation_i     = OP_FWD;
  logic signed [DataW-1:0] activation_in_i = '0;
  logic signed [DataW-1:0] grad_in_i       = '0;
  logic                    done_o;
  logic signed [DataW-1:0] value_out_o;

  elem_t           elem_backlog[$];
  due_t            sigmoid_due[$];
  longint unsigned sig_lut[TABLE_ENTRIES+1];

  int    n_errors     = 0;
  int    n_fwd        = 0;
  int    n_bwd        = 0;
  int    n_results    = 0;
  int    idle_left    = 0;
  int    calm_left    = 0;
  int    stall_cycles = 0;
  elem_t next_elem;
  logic  next_start;
  due_t  due_head;

  // clock
  always #1 clk_i = ~clk_i;

  sigmoid_activation_fwd_bwd_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .activation_in_i (activation_in_i),
    .grad_in_i       (grad_in_i),
    .done_o          (done_o),
    .value_out_o     (value_out_o)
  );

  // exp(-f) in q30, taylor series truncated after the term of order 24
  function automatic longint unsigned taylor_exp_neg(longint unsigned f);
    longint signed   acc;
    longint unsigned term;
    acc  = QONE;
    term = QONE;
    for (longint unsigned k = 1; k <= 24; k++) begin
      term = ((term * f) >> 30) / k;
      if (k[0]) acc -= longint'(term);
      else      acc += longint'(term);
    end
    return (acc < 0) ? 64'd0 : 64'(acc);
  endfunction

  // sigmoid samples at -8 + 16*i/entries, rounded half up
  initial begin
    longint unsigned em1, t, whole, rem, e, den, num;
    longint signed   a;
    em1 = taylor_exp_neg(QONE);
    for (int i = 0; i <= TABLE_ENTRIES; i++) begin
      a     = 16 * longint'(i) - 8 * longint'(TABLE_ENTRIES);
      t     = (a < 0) ? 64'(-a) : 64'(a);
      whole = t / TABLE_ENTRIES;
      rem   = t % TABLE_ENTRIES;
      e     = taylor_exp_neg((rem << 30) / TABLE_ENTRIES);
      repeat (whole) e = (e * em1) >> 30;
      den   = QONE + e;
      num   = (a >= 0) ? 64'(QONE) : e;
      sig_lut[i] = ((num << FRAC_BITS) + den / 2) / den;
    end
  end

  // expected value_out: interpolated sigmoid, or gradient times its derivative
  function automatic logic signed [DataW-1:0] sigmoid_unit_value(elem_t el);
    longint signed   x, g, res, xspan;
    longint unsigned u, p, idx, r, s, one, dspan, mag;
    x     = longint'($signed(el.act));
    g     = longint'($signed(el.grad));
    one   = longint'(1) << FRAC_BITS;
    dspan = longint'(16) << FRAC_BITS;
    xspan = longint'(8) << FRAC_BITS;
    if (x < -xspan) begin
      s = 0;
    end else if (x >= xspan) begin
      s = one;
    end else begin
      u   = x + xspan;
      p   = u * TABLE_ENTRIES;
      idx = p / dspan;
      r   = p % dspan;
      if (idx >= TABLE_ENTRIES) begin
        idx = TABLE_ENTRIES - 1;
        r   = dspan - 1;
      end
      s = (sig_lut[idx] * (dspan - r) + sig_lut[idx + 1] * r + dspan / 2) / dspan;
    end
    if (el.op == OP_FWD) begin
      res = s;
    end else begin
      // magnitude rounded half up, so ties go away from zero
      mag = ((g < 0) ? 64'(-g) : 64'(g)) * (s * (one - s));
      res = (mag + (longint'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
      if (g < 0) res = -res;
    end
    if (res > 32767) res = 32767;
    else if (res < -32768) res = -32768;
    return DataW'(res);
  endfunction

  task automatic queue_elem(logic op, logic signed [DataW-1:0] act,
                            logic signed [DataW-1:0] grad);
    elem_backlog.push_back('{op: op, act: act, grad: grad});
  endtask

  // driver: record accepted transactions, then present the next one or idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        next_elem = '{op: operation_i, act: activation_in_i, grad: grad_in_i};
        sigmoid_due.push_back('{elem: next_elem, value: sigmoid_unit_value(next_elem)});
        if (operation_i == OP_BWD) n_bwd++;
        else n_fwd++;
      end
      next_start = start && busy;
      if (!next_start) begin
        // occasional stretches with no idling at all
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 80);
        if (idle_left > 0) begin
          idle_left--;
        end else if (elem_backlog.size() > 0) begin
          if (calm_left == 0 && elem_backlog.size() > CALM_TAIL &&
              $urandom_range(0, 4) == 0) begin
            idle_left = $urandom_range(1, 6) - 1;
          end else begin
            next_elem = elem_backlog.pop_front();
            next_start = 1'b1;
            operation_i     <= next_elem.op;
            activation_in_i <= next_elem.act;
            grad_in_i       <= next_elem.grad;
          end
        end
      end
      start <= next_start;
    end
  end

  // monitor: compare each result with the oldest outstanding transaction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      n_results++;
      if (sigmoid_due.size() == 0) begin
        $display("%0t: unexpected result value_out=%0d", $time, value_out_o);
        n_errors++;
      end else begin
        due_head = sigmoid_due.pop_front();
        if (value_out_o !== due_head.value) begin
          $display("%0t: value_out mismatch op=%0b x=%0d grad=%0d expected %0d actual %0d",
                   $time, due_head.elem.op, due_head.elem.act, due_head.elem.grad,
                   due_head.value, value_out_o);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction in either direction
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, stall_cycles, sigmoid_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    elem_t el;
    // range ends, table segment boundaries and ignored gradient in forward mode
    queue_elem(OP_FWD, -32768, 0);
    queue_elem(OP_FWD, -32767, -1);
    queue_elem(OP_FWD, -1, 32767);
    queue_elem(OP_FWD, 0, -32768);
    queue_elem(OP_FWD, 1, 0);
    queue_elem(OP_FWD, 255, 0);
    queue_elem(OP_FWD, 256, 0);
    queue_elem(OP_FWD, -256, 0);
    queue_elem(OP_FWD, 32512, 0);
    queue_elem(OP_FWD, 32767, -1);
    queue_elem(OP_FWD, 21845, 12345);
    queue_elem(OP_FWD, -21846, -12346);
    // gradient extremes, peak derivative and sign handling
    queue_elem(OP_BWD, 0, 32767);
    queue_elem(OP_BWD, 0, -32768);
    queue_elem(OP_BWD, 0, 1);
    queue_elem(OP_BWD, 0, -1);
    queue_elem(OP_BWD, 0, 0);
    queue_elem(OP_BWD, -32768, -32768);
    queue_elem(OP_BWD, 32767, 32767);
    queue_elem(OP_BWD, 4096, -4096);
    queue_elem(OP_BWD, -4096, 4096);
    queue_elem(OP_BWD, 2048, 3);
    // random mix, some near zero and some small gradients for rounding ties
    for (int n = 0; n < RAND_ELEMS; n++) begin
      el.op   = ($urandom_range(0, 1) == 0) ? OP_FWD : OP_BWD;
      el.act  = ($urandom_range(0, 3) == 0) ? DataW'(int'($urandom_range(0, 4095)) - 2048)
                                            : DataW'($urandom());
      el.grad = ($urandom_range(0, 3) == 0) ? DataW'(int'($urandom_range(0, 63)) - 32)
                                            : DataW'($urandom());
      elem_backlog.push_back(el);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (elem_backlog.size() != 0 || start) @(posedge clk_i);
    while (sigmoid_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sigmoid_due.size() != 0) begin
      $display("%0t: %0d transactions never produced a result", $time, sigmoid_due.size());
      n_errors++;
    end
    $display("covered %0d forward and %0d backward transactions, %0d results checked",
             n_fwd, n_bwd, n_results);
    $display("%0d mismatches", n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
